// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL that checks its own logic (circular_deque_ring).
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
// No dependencies; imported by cdq_cell and circular_deque_ring.
package cdq_pkg;

  localparam int CDQ_DEPTH = 8;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam logic [CFG_W-1:0] RING_SIZE_RST = 4'd8;
  localparam logic [DATA_W-1:0] UNDERFLOW_VALUE = '1;

  typedef enum logic [1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } cdq_mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdq_status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_WAIT
  } cdq_fsm_e;

  typedef struct packed {
    cdq_mode_e          mode;
    logic [DATA_W-1:0]  data_in;
  } cdq_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  value_out;
    cdq_status_e        status;
    logic               now_full;
    logic               now_empty;
  } cdq_out_t;

  // Per-cell controls driven by the deque controller.
  typedef struct packed {
    logic push_front;  // take left neighbor (cell 0 takes write data)
    logic pop_front;   // take right neighbor
    logic load;        // take write data
    logic sel;         // drive own entry onto the read chain
  } cdq_cell_ctl_t;

endpackage

// ===== rtl/circular_deque_ring.sv =====
// Circular deque of up to DEPTH-1 entries of 32 bits, held in a row of cells with
// the front entry in cell 0. Push back, push front, pop front and any overflow or
// underflow leave busy low: the result is strobed on out_valid in the cycle after
// start, so a new start is taken every cycle. A pop back that finds an entry holds
// busy while the entry travels down the registered read chain through the cells
// to cell 0; its result is strobed in the first cycle with busy low again. The
// receiver cannot stall: every result is present for exactly one cycle. A cfg
// write (taken while not busy) sets ring_size, clamped to 2..DEPTH, and empties
// the deque; capacity is ring_size-1.
module circular_deque_ring
  import cdq_pkg::*;
#(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdq_in_t           in_data,
  output logic              out_valid,
  output cdq_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

`include "assert_macros.svh"

  localparam int CAP   = DEPTH - 1;
  localparam int CNT_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  cdq_fsm_e           state_r, state_nxt;
  logic [CFG_W-1:0]   ring_size_r, ring_size_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   wait_cnt_r, wait_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  cdq_out_t           out_r, out_nxt;

  logic [CNT_W-1:0]   cap;
  logic               full;
  logic               empty;
  logic               push_front;
  logic               pop_front;
  logic               push_back;

  logic [DATA_W-1:0]  cell_data  [CAP];
  logic [DATA_W-1:0]  cell_chain [CAP];
  cdq_cell_ctl_t      cell_ctl   [CAP];

  // Usable capacity from the clamped slot count.
  always_comb begin
    if (ring_size_r < 4'd2) begin
      cap = CNT_W'(1);
    end else if (int'({28'b0, ring_size_r}) > DEPTH) begin
      cap = CNT_W'(CAP);
    end else begin
      cap = CNT_W'(ring_size_r - 4'd1);
    end
  end

  assign full  = (cnt_r == cap);
  assign empty = (cnt_r == '0);

  always_comb begin
    state_nxt     = state_r;
    ring_size_nxt = ring_size_r;
    cnt_nxt       = cnt_r;
    wait_cnt_nxt  = wait_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    push_front    = 1'b0;
    pop_front     = 1'b0;
    push_back     = 1'b0;

    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          out_valid_nxt     = 1'b1;
          out_nxt.value_out = '0;
          out_nxt.status    = ST_OK;
          case (in_data.mode)
            MODE_PUSH_BACK: begin
              if (full) begin
                out_nxt.status = ST_OVERFLOW;
              end else begin
                push_back = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            MODE_PUSH_FRONT: begin
              if (full) begin
                out_nxt.status = ST_OVERFLOW;
              end else begin
                push_front = 1'b1;
                cnt_nxt    = cnt_r + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                out_nxt.status    = ST_UNDERFLOW;
                out_nxt.value_out = UNDERFLOW_VALUE;
              end else begin
                pop_front         = 1'b1;
                out_nxt.value_out = cell_data[0];
                cnt_nxt           = cnt_r - 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                out_nxt.status    = ST_UNDERFLOW;
                out_nxt.value_out = UNDERFLOW_VALUE;
              end else begin
                // Hold the result until the read chain has settled.
                out_valid_nxt = 1'b0;
                wait_cnt_nxt  = '0;
                state_nxt     = FSM_WAIT;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
        if (cfg_valid) begin
          ring_size_nxt = cfg_data;
          cnt_nxt       = '0;
        end
      end
      FSM_WAIT: begin
        wait_cnt_nxt = wait_cnt_r + 1'b1;
        if (wait_cnt_r == CNT_W'(CAP - 1)) begin
          out_valid_nxt     = 1'b1;
          out_nxt.value_out = cell_chain[0];
          out_nxt.status    = ST_OK;
          cnt_nxt           = cnt_r - 1'b1;
          state_nxt         = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase

    out_nxt.now_full  = (cnt_nxt == cap);
    out_nxt.now_empty = (cnt_nxt == '0);
    if (cfg_valid && state_r == FSM_IDLE) begin
      out_nxt.now_full  = 1'b0;
      out_nxt.now_empty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      ring_size_r <= RING_SIZE_RST;
      cnt_r       <= '0;
      wait_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_size_r <= ring_size_nxt;
      cnt_r       <= cnt_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      logic [DATA_W-1:0] chain_in;

      assign cell_ctl[gi].push_front = push_front;
      assign cell_ctl[gi].pop_front  = pop_front;
      assign cell_ctl[gi].load       = push_back && (cnt_r == CNT_W'(gi));
      assign cell_ctl[gi].sel        = (cnt_r == CNT_W'(gi + 1));

      if (gi == 0) begin : g_first
        assign left_data = in_data.data_in;
      end else begin : g_mid
        assign left_data = cell_data[gi-1];
      end

      if (gi == CAP - 1) begin : g_last
        assign right_data = cell_data[gi];
        assign chain_in   = '0;
      end else begin : g_inner
        assign right_data = cell_data[gi+1];
        assign chain_in   = cell_chain[gi+1];
      end

      cdq_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[gi]),
        .wr_data    (in_data.data_in),
        .left_data  (left_data),
        .right_data (right_data),
        .chain_in   (chain_in),
        .data       (cell_data[gi]),
        .chain_out  (cell_chain[gi])
      );
    end
  endgenerate

  assign busy      = (state_r != FSM_IDLE);
  assign cfg_ready = (state_r == FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMPL(a_cnt_in_cap, 1'b1, cnt_r <= cap)
  `ASSERT_IMPL(a_wait_no_strobe, state_r == FSM_WAIT, !out_valid_r)
  `ASSERT_IMPL(a_ovf_zero, out_valid_r && out_r.status == ST_OVERFLOW, out_r.value_out == '0)
  `ASSERT_NEXT(a_push_full_ovf,
               start && !busy && !cfg_valid && full &&
               (in_data.mode == MODE_PUSH_BACK || in_data.mode == MODE_PUSH_FRONT),
               out_valid_r && out_r.status == ST_OVERFLOW)

endmodule

// ===== rtl/cdq_cell.sv =====
// One storage cell of the deque: holds one entry and one read-chain stage.
// Depends on cdq_pkg for the data width and the cell control struct.
module cdq_cell
  import cdq_pkg::*;
(
  input  logic                clk,
  input  cdq_cell_ctl_t       ctl,
  input  logic [DATA_W-1:0]   wr_data,
  input  logic [DATA_W-1:0]   left_data,
  input  logic [DATA_W-1:0]   right_data,
  input  logic [DATA_W-1:0]   chain_in,
  output logic [DATA_W-1:0]   data,
  output logic [DATA_W-1:0]   chain_out
);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic [DATA_W-1:0] chain_r, chain_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = wr_data;
    end else if (ctl.push_front) begin
      data_nxt = left_data;
    end else if (ctl.pop_front) begin
      data_nxt = right_data;
    end
  end

  // Read chain advances one cell toward the front each cycle.
  assign chain_nxt = ctl.sel ? data_r : chain_in;

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    chain_r <= chain_nxt;
  end

  assign data      = data_r;
  assign chain_out = chain_r;

endmodule
